// ===== rtl/easter_holiday_dates_assert.svh =====
// ============================================================================
// easter_holiday_dates_assert.svh
// assertion macros shared by the easter date checker
// ============================================================================
`ifndef EASTER_HOLIDAY_DATES_ASSERT_SVH
`define EASTER_HOLIDAY_DATES_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define EHD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("easter date check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define EHD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("easter date check failed");

`endif

// ===== rtl/ehd_pkg.sv =====
// ============================================================================
// ehd_pkg
// shared types and widths for the easter date pipeline
// ============================================================================
package ehd_pkg;

    localparam int YEAR_W     = 14;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 40;
    localparam int OFF_W      = 6;

    // month and day of month
    typedef struct packed {
        logic [2:0] mon;
        logic [4:0] day;
    } date_t;

    // easter sunday plus what the feast stage needs
    typedef struct packed {
        date_t              easter;
        logic [OFF_W-1:0]   off;    // days after march 1
        logic               leap;
    } easter_t;

endpackage

// ===== rtl/easter_holiday_dates.sv =====
// throughput: one year per cycle while m_axis is not stalled; nine computus stages
//   and one output stage each hold a word, and stages fill bubbles while the output
//   is stalled
// reset: rst_n clears only the valid bits; data registers are left as they are
// ============================================================================
// easter_holiday_dates
// easter sunday, carnival, good friday, ascension and pentecost for a year
// ============================================================================
module easter_holiday_dates (
    input  logic                             clk,
    input  logic                             rst_n,
    // year stream in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ehd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [13:0] year, [15:14] zero
    // dates stream out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] easter_sunday_month, [7:3] easter_date, [9:8] carnival_month,
    // [14:10] carnival_date, [17:15] good_friday_month, [22:18] good_friday_date,
    // [25:23] pentecost_month, [30:26] pentecost_date, [33:31] ascension_month,
    // [38:34] ascension_date, [39] zero
    output logic [ehd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import ehd_pkg::*;

    // handoff between the computus pipeline and the feast stage
    logic    cmp_valid;
    logic    cmp_ready;
    easter_t cmp_word;

    // golden number, century terms, epact and weekday correction,
    // ending with easter as an offset from march 1
    ehd_computus u_computus (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .year      (s_axis_tdata[YEAR_W-1:0]),
        .out_valid (cmp_valid),
        .out_ready (cmp_ready),
        .result    (cmp_word)
    );

    // shifts the offset by each feast's distance from easter, maps back to
    // month and day (february length from the leap flag), registers the word
    ehd_feasts u_feasts (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmp_valid),
        .in_ready  (cmp_ready),
        .in_data   (cmp_word),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== rtl/ehd_computus.sv =====
// ============================================================================
// ehd_computus
// nine-stage pipeline of the anonymous gregorian computus
// ============================================================================
module ehd_computus (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ehd_pkg::YEAR_W-1:0]   year,
    output logic                         out_valid,
    input  logic                         out_ready,
    output ehd_pkg::easter_t             result
);
    import ehd_pkg::*;

    localparam int NSTG = 9;

    // reciprocal constants, each checked exact over the operand range
    localparam logic [12:0] RECIP_100 = 13'd5243;   // >> 19
    localparam logic [15:0] RECIP_19  = 16'd55189;  // >> 20
    localparam logic [5:0]  RECIP_25  = 6'd41;      // >> 10
    localparam logic [7:0]  RECIP_3   = 8'd171;     // >> 9
    localparam logic [9:0]  RECIP_30  = 10'd547;    // >> 14
    localparam logic [7:0]  RECIP_7   = 8'd147;     // >> 10
    localparam logic [8:0]  M_LIMIT   = 9'd451;
    localparam logic [5:0]  OFF_BIAS  = 6'd21;      // 114 minus days to march 1 (93)
    localparam logic [5:0]  APR_FIRST = 6'd31;

    logic [NSTG-1:0] vld_reg, vld_next, rdy;

    // ready ripples back through empty stages
    always_comb
    begin
        rdy[NSTG-1] = ~vld_reg[NSTG-1] | out_ready;
        for (int i = NSTG-2; i >= 0; i--)
        begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
        vld_next[0] = rdy[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];

    // stage 1: year / 100 and year / 19
    logic [26:0] p100;
    logic [29:0] p19;
    logic [13:0] s1_year_reg;
    logic [7:0]  s1_b_reg;
    logic [9:0]  s1_q19_reg;

    assign p100 = 27'(year) * 27'(RECIP_100);
    assign p19  = 30'(year) * 30'(RECIP_19);

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_year_reg <= year;
            s1_b_reg    <= p100[26:19];
            s1_q19_reg  <= p19[29:20];
        end
    end

    // stage 2: remainders, (b + 8) / 25, leap year
    logic [13:0] a_full, c_full;
    logic [14:0] p25;
    logic [4:0]  s2_a_reg;
    logic [7:0]  s2_b_reg;
    logic [6:0]  s2_c_reg;
    logic [2:0]  s2_f_reg;
    logic        s2_leap_reg;

    assign a_full = s1_year_reg - 14'(s1_q19_reg) * 14'd19;
    assign c_full = s1_year_reg - 14'(s1_b_reg) * 14'd100;
    assign p25    = (15'(s1_b_reg) + 15'd8) * 15'(RECIP_25);

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s2_a_reg    <= a_full[4:0];
            s2_b_reg    <= s1_b_reg;
            s2_c_reg    <= c_full[6:0];
            s2_f_reg    <= p25[12:10];
            s2_leap_reg <= (s1_year_reg[1:0] == 2'd0)
                           && ((c_full[6:0] != 7'd0) || (s1_b_reg[1:0] == 2'd0));
        end
    end

    // stage 3: g = (b - f + 1) / 3
    logic [15:0] p3;
    logic [4:0]  s3_a_reg;
    logic [7:0]  s3_b_reg;
    logic [6:0]  s3_c_reg;
    logic [5:0]  s3_g_reg;
    logic        s3_leap_reg;

    assign p3 = 16'(s2_b_reg - 8'(s2_f_reg) + 8'd1) * 16'(RECIP_3);

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            s3_a_reg    <= s2_a_reg;
            s3_b_reg    <= s2_b_reg;
            s3_c_reg    <= s2_c_reg;
            s3_g_reg    <= p3[14:9];
            s3_leap_reg <= s2_leap_reg;
        end
    end

    // stage 4: epact sum before mod 30
    logic [9:0] s4_hsum_reg;
    logic [4:0] s4_a_reg;
    logic [1:0] s4_e_reg;
    logic [6:0] s4_c_reg;
    logic       s4_leap_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            s4_hsum_reg <= 10'(s3_a_reg) * 10'd19 + 10'(s3_b_reg) + 10'd15
                           - 10'(s3_b_reg[7:2]) - 10'(s3_g_reg);
            s4_a_reg    <= s3_a_reg;
            s4_e_reg    <= s3_b_reg[1:0];
            s4_c_reg    <= s3_c_reg;
            s4_leap_reg <= s3_leap_reg;
        end
    end

    // stage 5: hsum / 30
    logic [19:0] p30;
    logic [9:0]  s5_hsum_reg;
    logic [4:0]  s5_q30_reg;
    logic [4:0]  s5_a_reg;
    logic [1:0]  s5_e_reg;
    logic [6:0]  s5_c_reg;
    logic        s5_leap_reg;

    assign p30 = 20'(s4_hsum_reg) * 20'(RECIP_30);

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            s5_hsum_reg <= s4_hsum_reg;
            s5_q30_reg  <= p30[18:14];
            s5_a_reg    <= s4_a_reg;
            s5_e_reg    <= s4_e_reg;
            s5_c_reg    <= s4_c_reg;
            s5_leap_reg <= s4_leap_reg;
        end
    end

    // stage 6: h and the weekday sum before mod 7
    logic [9:0] h_full;
    logic [4:0] h_val;
    logic [4:0] s6_h_reg;
    logic [6:0] s6_lsum_reg;
    logic [4:0] s6_a_reg;
    logic       s6_leap_reg;

    assign h_full = s5_hsum_reg - 10'(s5_q30_reg) * 10'd30;
    assign h_val  = h_full[4:0];

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            s6_h_reg    <= h_val;
            s6_lsum_reg <= 7'd32 + 7'({s5_e_reg, 1'b0}) + 7'({s5_c_reg[6:2], 1'b0})
                           - 7'(h_val) - 7'(s5_c_reg[1:0]);
            s6_a_reg    <= s5_a_reg;
            s6_leap_reg <= s5_leap_reg;
        end
    end

    // stage 7: lsum / 7
    logic [14:0] p7;
    logic [6:0]  s7_lsum_reg;
    logic [3:0]  s7_q7_reg;
    logic [4:0]  s7_h_reg;
    logic [4:0]  s7_a_reg;
    logic        s7_leap_reg;

    assign p7 = 15'(s6_lsum_reg) * 15'(RECIP_7);

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            s7_lsum_reg <= s6_lsum_reg;
            s7_q7_reg   <= p7[13:10];
            s7_h_reg    <= s6_h_reg;
            s7_a_reg    <= s6_a_reg;
            s7_leap_reg <= s6_leap_reg;
        end
    end

    // stage 8: l and the sum that decides m
    logic [6:0] l_full;
    logic [2:0] l_val;
    logic [4:0] s8_h_reg;
    logic [2:0] s8_l_reg;
    logic [8:0] s8_msum_reg;
    logic       s8_leap_reg;

    assign l_full = s7_lsum_reg - 7'(s7_q7_reg) * 7'd7;
    assign l_val  = l_full[2:0];

    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            s8_h_reg    <= s7_h_reg;
            s8_l_reg    <= l_val;
            s8_msum_reg <= 9'(s7_a_reg) + 9'(s7_h_reg) * 9'd11 + 9'(l_val) * 9'd22;
            s8_leap_reg <= s7_leap_reg;
        end
    end

    // stage 9: easter offset from march 1, month and day
    logic [5:0] off_val;
    easter_t    s9_res_reg;

    assign off_val = 6'(s8_h_reg) + 6'(s8_l_reg) + OFF_BIAS
                     - ((s8_msum_reg >= M_LIMIT) ? 6'd7 : 6'd0);

    always_ff @(posedge clk)
    begin
        if (rdy[8])
        begin
            s9_res_reg.off  <= off_val;
            s9_res_reg.leap <= s8_leap_reg;
            if (off_val >= APR_FIRST)
            begin
                s9_res_reg.easter.mon <= 3'd4;
                s9_res_reg.easter.day <= 5'(off_val - 6'd30);
            end
            else
            begin
                s9_res_reg.easter.mon <= 3'd3;
                s9_res_reg.easter.day <= 5'(off_val + 6'd1);
            end
        end
    end

    assign result = s9_res_reg;

endmodule

// ===== rtl/ehd_feasts.sv =====
// ============================================================================
// ehd_feasts
// derives the four movable feasts from easter and registers the output word
// ============================================================================
module ehd_feasts (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ehd_pkg::easter_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ehd_pkg::OUT_TDATA_W-1:0]   out_data
);
    import ehd_pkg::*;

    localparam logic signed [7:0] CARNIVAL_SHIFT  = -8'sd49;
    localparam logic signed [7:0] GOOD_FRI_SHIFT  = -8'sd2;
    localparam logic signed [7:0] PENTECOST_SHIFT = 8'sd49;
    localparam logic signed [7:0] ASCENSION_SHIFT = 8'sd39;

    // offset from march 1 (negative reaches into february) to month and day
    function automatic date_t march_to_date(logic signed [7:0] off, logic leap);
        date_t             r;
        logic [4:0]        feb;
        logic signed [7:0] tmp;
        feb = leap ? 5'd29 : 5'd28;
        tmp = off;
        if (off < 8'sd0)
        begin
            r.mon = 3'd2;
            r.day = feb + off[4:0] + 5'd1;
        end
        else if (off < 8'sd31)
        begin
            r.mon = 3'd3;
            r.day = off[4:0] + 5'd1;
        end
        else if (off < 8'sd61)
        begin
            r.mon = 3'd4;
            tmp   = off - 8'sd30;
            r.day = tmp[4:0];
        end
        else if (off < 8'sd92)
        begin
            r.mon = 3'd5;
            tmp   = off - 8'sd60;
            r.day = tmp[4:0];
        end
        else
        begin
            r.mon = 3'd6;
            tmp   = off - 8'sd91;
            r.day = tmp[4:0];
        end
        return r;
    endfunction

    logic signed [7:0]      off_s;
    date_t                  carnival, good_fri, pentecost, ascension;
    logic                   vld_reg;
    logic [OUT_TDATA_W-1:0] data_reg;

    assign off_s     = $signed({2'b00, in_data.off});
    assign carnival  = march_to_date(off_s + CARNIVAL_SHIFT, in_data.leap);
    assign good_fri  = march_to_date(off_s + GOOD_FRI_SHIFT, in_data.leap);
    assign pentecost = march_to_date(off_s + PENTECOST_SHIFT, in_data.leap);
    assign ascension = march_to_date(off_s + ASCENSION_SHIFT, in_data.leap);

    assign in_ready = ~vld_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            data_reg <= {1'b0,
                         ascension.day, ascension.mon,
                         pentecost.day, pentecost.mon,
                         good_fri.day, good_fri.mon,
                         carnival.day, carnival.mon[1:0],
                         in_data.easter.day, in_data.easter.mon};
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/ehd_checker.sv =====
// ============================================================================
// ehd_checker
// port-level checks on the easter date block, bound to its top level
// ============================================================================
`include "easter_holiday_dates_assert.svh"

module ehd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [ehd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ehd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    // a stalled result word holds
    `EHD_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // easter falls in march or april and the pad bit stays clear
    `EHD_ASSERT_IMP(a_easter_month, m_axis_tvalid, (m_axis_tdata[2:0] == 3'd3 || m_axis_tdata[2:0] == 3'd4) && !m_axis_tdata[39])

    // easter in march puts good friday two days earlier in march
    `EHD_ASSERT_IMP(a_good_friday, m_axis_tvalid && m_axis_tdata[2:0] == 3'd3, m_axis_tdata[17:15] == 3'd3 && m_axis_tdata[22:18] == m_axis_tdata[7:3] - 5'd2)

    // pentecost is ten days after ascension
    `EHD_ASSERT_IMP(a_pentecost_gap, m_axis_tvalid && m_axis_tdata[33:31] == m_axis_tdata[25:23], m_axis_tdata[30:26] == m_axis_tdata[38:34] + 5'd10)

endmodule

bind easter_holiday_dates ehd_checker u_ehd_checker (.*);

// ===== dv/holiday_date_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// holiday_date_checker
// watches the year and date streams, predicts each date word from the year
// and compares it field by field with what the block returns
// ============================================================================
module holiday_date_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [ehd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [13:0] year, [15:14] zero
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] easter_sunday_month, [7:3] easter_date, [9:8] carnival_month,
    // [14:10] carnival_date, [17:15] good_friday_month, [22:18] good_friday_date,
    // [25:23] pentecost_month, [30:26] pentecost_date, [33:31] ascension_month,
    // [38:34] ascension_date, [39] zero
    input  logic [ehd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output int                               fail_count,
    output int                               words_pending,
    output int                               years_taken,
    output int                               words_checked
);

    // date word as it sits on m_axis_tdata, msb first
    typedef struct packed {
        logic       pad;
        logic [4:0] ascension_date;
        logic [2:0] ascension_month;
        logic [4:0] pentecost_date;
        logic [2:0] pentecost_month;
        logic [4:0] good_friday_date;
        logic [2:0] good_friday_month;
        logic [4:0] carnival_date;
        logic [1:0] carnival_month;
        logic [4:0] easter_date;
        logic [2:0] easter_sunday_month;
    } holiday_word_t;

    holiday_word_t expected_dates[$];

    initial
    begin
        fail_count    = 0;
        words_pending = 0;
        years_taken   = 0;
        words_checked = 0;
    end

    // days after march 1 (negative reaches into february) to month and day
    function automatic void march_offset_to_date(input int days_after, input int feb_len,
                                                 output int mon, output int day);
        if (days_after < 0)
        begin
            mon = 2;
            day = feb_len + days_after + 1;
        end
        else if (days_after < 31)
        begin
            mon = 3;
            day = days_after + 1;
        end
        else if (days_after < 61)
        begin
            mon = 4;
            day = days_after - 30;
        end
        else if (days_after < 92)
        begin
            mon = 5;
            day = days_after - 60;
        end
        else
        begin
            mon = 6;
            day = days_after - 91;
        end
    endfunction

    // anonymous gregorian computus, then the four feasts around easter
    function automatic holiday_word_t compute_holy_days(input logic [ehd_pkg::YEAR_W-1:0] yr);
        int y, a, b, c, d, e, f, g, h, i, k, l, m;
        int base, emon, eday, feb_len, days_after, mon, day;
        holiday_word_t w;
        y = int'(yr);
        a = y % 19;
        b = y / 100;
        c = y % 100;
        d = b / 4;
        e = b % 4;
        f = (b + 8) / 25;
        g = (b - f + 1) / 3;
        h = (19 * a + b + 15 - d - g) % 30;
        i = c / 4;
        k = c % 4;
        l = (32 + 2 * e + 2 * i - h - k) % 7;
        m = (a + 11 * h + 22 * l) / 451;
        base = h + l + 114 - 7 * m;
        emon = base / 31;
        eday = base % 31 + 1;
        feb_len = ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
        days_after = (emon == 4) ? 30 + eday : eday - 1;

        w = '0;
        w.easter_sunday_month = 3'(emon);
        w.easter_date  = 5'(eday);
        march_offset_to_date(days_after - 49, feb_len, mon, day);
        w.carnival_month = 2'(mon);
        w.carnival_date  = 5'(day);
        march_offset_to_date(days_after - 2, feb_len, mon, day);
        w.good_friday_month = 3'(mon);
        w.good_friday_date  = 5'(day);
        march_offset_to_date(days_after + 49, feb_len, mon, day);
        w.pentecost_month = 3'(mon);
        w.pentecost_date  = 5'(day);
        march_offset_to_date(days_after + 39, feb_len, mon, day);
        w.ascension_month = 3'(mon);
        w.ascension_date  = 5'(day);
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [4:0] exp_val,
                                        input logic [4:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        holiday_word_t exp_word;
        holiday_word_t got_word;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_word = holiday_word_t'(m_axis_tdata);
                if (expected_dates.size() == 0)
                begin
                    $error("date word with no year outstanding: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_word = expected_dates.pop_front();
                    check_field("easter_sunday_month", exp_word.easter_sunday_month,
                                got_word.easter_sunday_month);
                    check_field("easter_date", exp_word.easter_date, got_word.easter_date);
                    check_field("carnival_month", exp_word.carnival_month,
                                got_word.carnival_month);
                    check_field("carnival_date", exp_word.carnival_date,
                                got_word.carnival_date);
                    check_field("good_friday_month", exp_word.good_friday_month,
                                got_word.good_friday_month);
                    check_field("good_friday_date", exp_word.good_friday_date,
                                got_word.good_friday_date);
                    check_field("pentecost_month", exp_word.pentecost_month,
                                got_word.pentecost_month);
                    check_field("pentecost_date", exp_word.pentecost_date,
                                got_word.pentecost_date);
                    check_field("ascension_month", exp_word.ascension_month,
                                got_word.ascension_month);
                    check_field("ascension_date", exp_word.ascension_date,
                                got_word.ascension_date);
                    check_field("pad", exp_word.pad, got_word.pad);
                    words_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_dates.push_back(compute_holy_days(s_axis_tdata[ehd_pkg::YEAR_W-1:0]));
                years_taken++;
            end
            words_pending = expected_dates.size();
        end
    end

endmodule

// ===== dv/tb_easter_holiday_dates.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_easter_holiday_dates
// drives years into the easter date pipeline and gives the verdict; the
// checker beside the block predicts and compares every date word
// ============================================================================
module tb_easter_holiday_dates;

    import ehd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;   // far above the slowest legal run
    localparam int DRAIN_CYCLES = 20;       // pipeline is 10 deep
    localparam int HOLD_CYCLES  = 300;      // long output stall, fills the pipeline
    localparam int YEAR_MAX     = (1 << YEAR_W) - 1;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;     // [13:0] year, [15:14] zero
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;          // ten date fields, see checker

    int fail_count;
    int words_pending;
    int years_taken;
    int words_checked;

    // idling knobs, changed per phase by the stimulus
    int sender_max_gap     = 3;
    int receiver_max_stall = 3;
    int hold_off_cycles    = 0;     // one-shot request for a long output stall
    int longest_hold       = 0;
    int cycle_count        = 0;

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    easter_holiday_dates u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    holiday_date_checker u_date_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .years_taken   (years_taken),
        .words_checked (words_checked)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still outstanding",
                     cycle_count, words_pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // offer one year word; tvalid is only dropped when a gap is drawn, so a
    // back-to-back word never sees tvalid lowered and raised in one step
    task automatic send_year(input int yr);
        int gap;
        gap = $urandom_range(0, sender_max_gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - YEAR_W){1'b0}}, YEAR_W'(yr)};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // stop offering and wait until every date word has come back
    task automatic drain_dates();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (words_pending != 0);
    endtask

    // mostly the whole 14-bit range, some weight on years near today
    function automatic int pick_year();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, YEAR_MAX);
        else
            return $urandom_range(1583, 2600);
    endfunction

    task automatic send_random_years(input int count);
        repeat (count) send_year(pick_year());
    endtask

    // receiver: draws a stall per word, or takes a pending long hold-off
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            stall = (hold_off_cycles > 0) ? hold_off_cycles
                                          : $urandom_range(0, receiver_max_stall);
            if (hold_off_cycles > 0)
                longest_hold = hold_off_cycles;
            hold_off_cycles = 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // stimulus
    initial
    begin
        int corner_years[$];

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: field extremes, year zero as a leap year,
        // pre-reform years, century leap rules, easter on april 1 and 2
        // (good friday back in march), earliest and latest easter,
        // carnival across a leap february and alternating bit patterns
        corner_years = '{0, 1, 4, 100, 400, 1582, 1583, 1818, 1900, 1943, 1961,
                         2000, 2008, 2018, 2024, 2029, 2038, 2100, 2285, 2400,
                         5461, 8192, 10922, YEAR_MAX};
        foreach (corner_years[n])
            send_year(corner_years[n]);

        // sender pauses until the pipeline is empty
        drain_dates();

        // random years with random idling on both sides
        send_random_years(200);

        // no idling at all: full rate in and out
        sender_max_gap     = 0;
        receiver_max_stall = 0;
        send_random_years(150);

        // long output hold while years keep coming, so input backs up
        drain_dates();
        hold_off_cycles = HOLD_CYCLES;
        send_random_years(60);
        sender_max_gap     = 3;
        receiver_max_stall = 3;
        drain_dates();

        send_random_years(240);

        // end of stimulus, let the pipeline empty out
        drain_dates();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d years sent, %0d date words checked, %0d mismatches",
                 years_taken, words_checked, fail_count);
        $display("corner years, full-range random years, gapless bursts, %0d-cycle output hold",
                 longest_hold);
        if (fail_count == 0 && words_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
